/* src/sfs_pkg.sv */
// Shared constants for the smooth follow step block.
package sfs_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int LEASH_WIDTH = 31;
  localparam int LAG_WIDTH = 17;
  localparam int LAG_BITS = 16;
  localparam int CFG_DATA_WIDTH = 31;

  localparam logic [LAG_WIDTH-1:0] LAG_ONE = 17'd65536;
  localparam logic [LEASH_WIDTH-1:0] LEASH_RESET = 31'd0;
  localparam logic [LAG_WIDTH-1:0] LAG_RESET = 17'd6554;

  // Configuration register indexes.
  localparam logic CFG_LEASH = 1'b0;
  localparam logic CFG_LAG = 1'b1;

endpackage

/* src/smooth_follow_step_top.sv */
// Smooth follow step: leash-limited follower update, fully pipelined.
//
// Usage: pulse start with a follower and a target position (signed fixed
// point, COORD_WIDTH bits each). busy is always low, so a new beat may be
// given on every clock. Each beat produces exactly one result: out_valid is
// high for one cycle with out_new_x and out_new_y; the receiver cannot stall.
// Throughput is one beat per cycle.
// The path is: difference, magnitude, squares, sum, a square root that
// resolves one root bit per stage, two multiplier stages, and a restoring
// divider that resolves one quotient bit per stage, then a saturating add.
// The divider stage count, COORD_WIDTH+17, and the root stage count,
// COORD_WIDTH+1, set the latency.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 leash
// distance, 1 lag factor). Write only while no beat is in flight.
// Reset (synchronous, rst_n low) clears all stage valid bits and sets the
// leash to 0 and the lag factor to 6554; beats in flight are dropped.
module smooth_follow_step_top #(
  parameter int COORD_WIDTH = sfs_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_follower_x,
  input  logic signed [COORD_WIDTH-1:0]     in_follower_y,
  input  logic signed [COORD_WIDTH-1:0]     in_target_x,
  input  logic signed [COORD_WIDTH-1:0]     in_target_y,
  output logic                              out_valid,
  output logic signed [COORD_WIDTH-1:0]     out_new_x,
  output logic signed [COORD_WIDTH-1:0]     out_new_y,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [sfs_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

  localparam int W = COORD_WIDTH;
  localparam int R = W + 1;                    // root and magnitude width
  localparam int N = 2 * R;                    // radicand width
  localparam int RW = R + 3;                   // root remainder width
  localparam int QB = W + sfs_pkg::LAG_BITS + 1; // quotient bits
  localparam int PW = 2 * R + sfs_pkg::LAG_WIDTH; // dividend width
  localparam int CW = (R > sfs_pkg::LEASH_WIDTH) ? R : sfs_pkg::LEASH_WIDTH;

  typedef struct packed {
    logic [W-1:0] fx;
    logic [W-1:0] fy;
    logic         nx;
    logic         ny;
    logic [R-1:0] ax;
    logic [R-1:0] ay;
  } side_t;

  // Configuration registers.
  logic [sfs_pkg::LEASH_WIDTH-1:0] leash_r;
  logic [sfs_pkg::LAG_WIDTH-1:0]   lag_r;
  logic [sfs_pkg::LAG_WIDTH-1:0]   lag_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leash_r <= sfs_pkg::LEASH_RESET;
      lag_r   <= sfs_pkg::LAG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfs_pkg::CFG_LEASH: leash_r <= cfg_data[sfs_pkg::LEASH_WIDTH-1:0];
        sfs_pkg::CFG_LAG:   lag_r   <= cfg_data[sfs_pkg::LAG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign lag_c = (lag_r > sfs_pkg::LAG_ONE) ? sfs_pkg::LAG_ONE : lag_r;
  assign busy = 1'b0;

  // Stage A: differences.
  logic                a_vld_r;
  logic [W-1:0]        a_fx_r, a_fy_r;
  logic signed [W:0]   a_dx_r, a_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else a_vld_r <= start;
  end

  always_ff @(posedge clk) begin
    a_fx_r <= in_follower_x;
    a_fy_r <= in_follower_y;
    a_dx_r <= {in_target_x[W-1], in_target_x} - {in_follower_x[W-1], in_follower_x};
    a_dy_r <= {in_target_y[W-1], in_target_y} - {in_follower_y[W-1], in_follower_y};
  end

  // Stage B: magnitudes and signs.
  logic  b_vld_r;
  side_t b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    b_side_r.fx <= a_fx_r;
    b_side_r.fy <= a_fy_r;
    b_side_r.nx <= a_dx_r[W];
    b_side_r.ny <= a_dy_r[W];
    b_side_r.ax <= a_dx_r[W] ? R'(-a_dx_r) : R'(a_dx_r);
    b_side_r.ay <= a_dy_r[W] ? R'(-a_dy_r) : R'(a_dy_r);
  end

  // Stage C: squares.
  logic         c_vld_r;
  side_t        c_side_r;
  logic [N-1:0] c_sqx_r, c_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    c_side_r <= b_side_r;
    c_sqx_r  <= N'(b_side_r.ax) * N'(b_side_r.ax);
    c_sqy_r  <= N'(b_side_r.ay) * N'(b_side_r.ay);
  end

  // Square root pipeline; entry 0 holds the sum of squares.
  logic          sq_vld_r  [R+1];
  side_t         sq_side_r [R+1];
  logic [N-1:0]  sq_rad_r  [R+1];
  logic [RW-1:0] sq_rem_r  [R+1];
  logic [R-1:0]  sq_root_r [R+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_vld_r[0] <= 1'b0;
    else sq_vld_r[0] <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    sq_side_r[0] <= c_side_r;
    sq_rad_r[0]  <= c_sqx_r + c_sqy_r;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  for (genvar k = 0; k < R; k++) begin : g_sqrt
    logic [RW-1:0] rem2, trial;
    logic          ge;

    // One root bit: bring down two radicand bits and try root*4+1.
    assign rem2  = {sq_rem_r[k][RW-3:0], sq_rad_r[k][N-1:N-2]};
    assign trial = {{(RW-R-2){1'b0}}, sq_root_r[k], 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k+1] <= 1'b0;
      else sq_vld_r[k+1] <= sq_vld_r[k];
    end

    always_ff @(posedge clk) begin
      sq_side_r[k+1] <= sq_side_r[k];
      sq_rad_r[k+1]  <= {sq_rad_r[k][N-3:0], 2'b00};
      sq_rem_r[k+1]  <= ge ? (rem2 - trial) : rem2;
      sq_root_r[k+1] <= {sq_root_r[k][R-2:0], ge};
    end
  end

  // Stage M1: leash test and first product.
  logic [R-1:0]  root_dist;
  logic [CW-1:0] dist_ext, leash_ext;
  logic          pulled;
  logic [R-1:0]  scale, divisor;

  assign root_dist = sq_root_r[R];
  assign dist_ext  = CW'(root_dist);
  assign leash_ext = CW'(leash_r);
  assign pulled    = (dist_ext > leash_ext);
  assign scale     = pulled ? R'(dist_ext - leash_ext) : R'(1);
  // Inside the leash the divide is by one, so the quotient is the product.
  assign divisor   = pulled ? root_dist : R'(1);

  logic         m1_vld_r;
  side_t        m1_side_r;
  logic [R-1:0] m1_div_r;
  logic [N-1:0] m1_px_r, m1_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_vld_r <= 1'b0;
    else m1_vld_r <= sq_vld_r[R];
  end

  always_ff @(posedge clk) begin
    m1_side_r <= sq_side_r[R];
    m1_div_r  <= divisor;
    m1_px_r   <= N'(sq_side_r[R].ax) * N'(scale);
    m1_py_r   <= N'(sq_side_r[R].ay) * N'(scale);
  end

  // Divider pipeline; entry 0 holds the lag product.
  logic          dv_vld_r  [QB+1];
  side_t         dv_side_r [QB+1];
  logic [R-1:0]  dv_div_r  [QB+1];
  logic [PW-1:0] dv_nx_r   [QB+1];
  logic [PW-1:0] dv_ny_r   [QB+1];
  logic [R-1:0]  dv_rx_r   [QB+1];
  logic [R-1:0]  dv_ry_r   [QB+1];
  logic [QB-1:0] dv_qx_r   [QB+1];
  logic [QB-1:0] dv_qy_r   [QB+1];
  logic [PW-1:0] lag_px, lag_py;

  assign lag_px = PW'(m1_px_r) * PW'(lag_c);
  assign lag_py = PW'(m1_py_r) * PW'(lag_c);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else dv_vld_r[0] <= m1_vld_r;
  end

  // The high dividend bits are already below the divisor.
  always_ff @(posedge clk) begin
    dv_side_r[0] <= m1_side_r;
    dv_div_r[0]  <= m1_div_r;
    dv_nx_r[0]   <= lag_px;
    dv_ny_r[0]   <= lag_py;
    dv_rx_r[0]   <= lag_px[QB+R-1:QB];
    dv_ry_r[0]   <= lag_py[QB+R-1:QB];
    dv_qx_r[0]   <= '0;
    dv_qy_r[0]   <= '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [R:0] tx, ty, dext;
    logic       gex, gey;

    assign dext = {1'b0, dv_div_r[k]};
    assign tx   = {dv_rx_r[k], dv_nx_r[k][QB-1-k]};
    assign ty   = {dv_ry_r[k], dv_ny_r[k][QB-1-k]};
    assign gex  = (tx >= dext);
    assign gey  = (ty >= dext);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[k+1] <= 1'b0;
      else dv_vld_r[k+1] <= dv_vld_r[k];
    end

    always_ff @(posedge clk) begin
      dv_side_r[k+1] <= dv_side_r[k];
      dv_div_r[k+1]  <= dv_div_r[k];
      dv_nx_r[k+1]   <= dv_nx_r[k];
      dv_ny_r[k+1]   <= dv_ny_r[k];
      dv_rx_r[k+1]   <= gex ? R'(tx - dext) : tx[R-1:0];
      dv_ry_r[k+1]   <= gey ? R'(ty - dext) : ty[R-1:0];
      dv_qx_r[k+1]   <= {dv_qx_r[k][QB-2:0], gex};
      dv_qy_r[k+1]   <= {dv_qy_r[k][QB-2:0], gey};
    end
  end

  // Output stage: apply the move and saturate.
  side_t        fin;
  logic [R-1:0] magx, magy;
  logic [W+1:0] sumx, sumy;

  assign fin  = dv_side_r[QB];
  assign magx = dv_qx_r[QB][QB-1:sfs_pkg::LAG_BITS];
  assign magy = dv_qy_r[QB][QB-1:sfs_pkg::LAG_BITS];
  assign sumx = fin.nx ? ({{2{fin.fx[W-1]}}, fin.fx} - {1'b0, magx})
                       : ({{2{fin.fx[W-1]}}, fin.fx} + {1'b0, magx});
  assign sumy = fin.ny ? ({{2{fin.fy[W-1]}}, fin.fy} - {1'b0, magy})
                       : ({{2{fin.fy[W-1]}}, fin.fy} + {1'b0, magy});

  function automatic logic [W-1:0] sat(input logic [W+1:0] v);
    logic [W-1:0] res;
    if ((v[W+1] == v[W]) && (v[W] == v[W-1])) res = v[W-1:0];
    else if (v[W+1]) res = {1'b1, {(W-1){1'b0}}};
    else res = {1'b0, {(W-1){1'b1}}};
    return res;
  endfunction

  logic         out_valid_r;
  logic [W-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= dv_vld_r[QB];
  end

  always_ff @(posedge clk) begin
    out_x_r <= sat(sumx);
    out_y_r <= sat(sumy);
  end

  assign out_valid = out_valid_r;
  assign out_new_x = out_x_r;
  assign out_new_y = out_y_r;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the smooth follow step block.
`timescale 1ns / 1ps

module tb;

  localparam int CW = 32;
  localparam int LATENCY = 2 * CW + 25;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [CW-1:0] fx, fy, tx, ty;
    bit                   typed;
    logic signed [CW-1:0] nx, ny;
  } step_row_t;

  typedef struct {
    logic signed [CW-1:0] nx, ny;
  } position_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_follower_x = '0, in_follower_y = '0;
  logic signed [CW-1:0] in_target_x = '0, in_target_y = '0;
  logic out_valid;
  logic signed [CW-1:0] out_new_x, out_new_y;
  logic cfg_we = 1'b0;
  logic cfg_index = sfs_pkg::CFG_LEASH;
  logic [sfs_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // Typed expectation for the beat currently on the input ports.
  logic typed_beat = 1'b0;
  logic signed [CW-1:0] typed_x = '0, typed_y = '0;

  logic [sfs_pkg::LEASH_WIDTH-1:0] leash_reg = sfs_pkg::LEASH_RESET;
  logic [sfs_pkg::LAG_WIDTH-1:0]   lag_reg = sfs_pkg::LAG_RESET;

  position_t pending_positions[$];
  int errors = 0;
  int cycles = 0;

  smooth_follow_step_top #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_follower_x(in_follower_x), .in_follower_y(in_follower_y),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .out_valid(out_valid), .out_new_x(out_new_x), .out_new_y(out_new_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [127:0] root_floor(logic [127:0] n);
    logic [127:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] axis_step(logic signed [CW-1:0] f,
      logic signed [127:0] delta, logic [127:0] d, bit pulled);
    logic [127:0] a, p, lag;
    logic signed [127:0] fe, v;
    lag = (lag_reg > sfs_pkg::LAG_ONE) ? 128'(sfs_pkg::LAG_ONE) : 128'(lag_reg);
    a = (delta < 0) ? 128'(-delta) : 128'(delta);
    if (pulled) p = (a * (d - 128'(leash_reg)) * lag) / d;
    else p = a * lag;
    fe = f;
    v = (delta < 0) ? fe - $signed(p >> sfs_pkg::LAG_BITS)
                    : fe + $signed(p >> sfs_pkg::LAG_BITS);
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    return v[CW-1:0];
  endfunction

  function automatic position_t follow_step(logic signed [CW-1:0] fx, fy, tx, ty);
    logic signed [127:0] dx, dy;
    logic [127:0] d;
    bit pulled;
    position_t r;
    dx = 128'(tx) - 128'(fx);
    dy = 128'(ty) - 128'(fy);
    d = root_floor(128'(dx * dx) + 128'(dy * dy));
    pulled = d > 128'(leash_reg);
    r.nx = axis_step(fx, dx, d, pulled);
    r.ny = axis_step(fy, dy, d, pulled);
    return r;
  endfunction

  // Record what each accepted beat should produce, and check each result.
  always @(posedge clk) begin
    position_t want;
    cycles <= cycles + 1;
    if (rst_n && start && !busy) begin
      if (typed_beat) begin
        want.nx = typed_x;
        want.ny = typed_y;
      end else begin
        want = follow_step(in_follower_x, in_follower_y, in_target_x, in_target_y);
      end
      pending_positions.push_back(want);
    end
    if (rst_n && out_valid) begin
      if (pending_positions.size() == 0) begin
        $error("result with no beat outstanding: new_x %0d new_y %0d", out_new_x, out_new_y);
        errors = errors + 1;
      end else begin
        want = pending_positions.pop_front();
        if (out_new_x !== want.nx) begin
          $error("new_x: expected %0d, actual %0d", want.nx, out_new_x);
          errors = errors + 1;
        end
        if (out_new_y !== want.ny) begin
          $error("new_y: expected %0d, actual %0d", want.ny, out_new_y);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(logic signed [CW-1:0] fx, fy, tx, ty, bit typed = 0,
      logic signed [CW-1:0] ex = '0, logic signed [CW-1:0] ey = '0);
    start <= 1'b1;
    in_follower_x <= fx;
    in_follower_y <= fy;
    in_target_x <= tx;
    in_target_y <= ty;
    typed_beat <= typed;
    typed_x <= ex;
    typed_y <= ey;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [sfs_pkg::CFG_DATA_WIDTH-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sfs_pkg::CFG_LEASH) leash_reg = value[sfs_pkg::LEASH_WIDTH-1:0];
    else lag_reg = value[sfs_pkg::LAG_WIDTH-1:0];
  endtask

  function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] base, int span);
    return base + $signed(CW'($urandom_range(2 * span, 0))) - span;
  endfunction

  initial begin
    localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
    localparam logic signed [CW-1:0] MINC = 32'sh80000000;
    step_row_t rows[$];
    int idle_pct[4] = '{0, 57, 0, 32};
    logic [sfs_pkg::CFG_DATA_WIDTH-1:0] leash_set[8];
    logic [sfs_pkg::CFG_DATA_WIDTH-1:0] lag_set[8];
    logic signed [CW-1:0] fx, fy;
    int span;

    // Zero distance leaves the follower where it is, at any position.
    rows.push_back('{0, 0, 0, 0, 1, 0, 0});
    rows.push_back('{MAXC, MAXC, MAXC, MAXC, 1, MAXC, MAXC});
    rows.push_back('{MINC, MINC, MINC, MINC, 1, MINC, MINC});
    rows.push_back('{MAXC, MINC, MAXC, MINC, 1, MAXC, MINC});
    rows.push_back('{-5, 77, -5, 77, 1, -5, 77});
    // Widest differences in several directions, then smaller ones.
    rows.push_back('{MINC, MINC, MAXC, MAXC, 0, 0, 0});
    rows.push_back('{MAXC, MAXC, MINC, MINC, 0, 0, 0});
    rows.push_back('{MINC, MAXC, MAXC, MINC, 0, 0, 0});
    rows.push_back('{MAXC, 0, MINC, 0, 0, 0, 0});
    rows.push_back('{0, MINC, 0, MAXC, 0, 0, 0});
    rows.push_back('{0, 0, 1, 0, 0, 0, 0});
    rows.push_back('{0, 0, -1, -1, 0, 0, 0});
    rows.push_back('{32'h10000, 32'h20000, 32'h50000, 32'h60000, 0, 0, 0});
    rows.push_back('{-32'sh30000, 0, 0, 32'sh40000, 0, 0, 0});
    rows.push_back('{32'sh5555aaaa, 32'shaaaa5555, 32'sh0f0f0f0f, 32'shf0f0f0f0, 0, 0, 0});

    leash_set = '{31'h7fffffff, 0, 31'h50000, 31'h1, 31'h7fffffff, 0, 31'h2000000, 31'h30000};
    lag_set = '{65536, 0, 131071, 65536, 1, 65537, 32768, 6554};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_beat(rows[i].fx, rows[i].fy, rows[i].tx, rows[i].ty, rows[i].typed,
                rows[i].nx, rows[i].ny);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(sfs_pkg::CFG_LEASH, (ph == 3) ? 31'($urandom()) : leash_set[ph]);
      write_reg(sfs_pkg::CFG_LAG,
                (ph == 7) ? 31'($urandom_range(65536, 0)) : lag_set[ph]);
      for (int k = 0; k < 55; k++) begin
        fx = $urandom();
        fy = $urandom();
        case ($urandom_range(3, 0))
          0: send_beat(fx, fy, $urandom(), $urandom());
          1: send_beat(fx, fy, fx, fy);
          default: begin
            // Differences of the order of the leash, so both branches are hit.
            span = (leash_reg == 0 || leash_reg > 31'h3fffffff) ?
                   int'($urandom_range(32'h100000, 1)) : int'(leash_reg);
            send_beat(fx, fy, near(fx, span), near(fy, span));
          end
        endcase
        if ($urandom_range(99, 0) < idle_pct[ph % 4]) begin
          start <= 1'b0;
          repeat ($urandom_range(6, 1)) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sfs_pkg.sv
src/smooth_follow_step_top.sv
tb/tb.sv
